// ----- src/multirotor_cascaded_pid_mixer_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multirotor cascaded PID mixer
// Each macro expands to one labeled concurrent assertion that is clocked on
// clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTIROTOR_CASCADED_PID_MIXER_TOP_MACROS_SVH
`define MULTIROTOR_CASCADED_PID_MIXER_TOP_MACROS_SVH

// Same-cycle implication.
`define MCPM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCPM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpm_pkg
// Shared types, constants and helpers of the multirotor cascaded PID mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpm_pkg;

  typedef logic signed [33:0] opnd_t;
  typedef logic signed [63:0] acc_t;

  // Post-multiply scaling of the shared multiply-accumulate unit.
  typedef enum logic [3:0] {
    SH_0, SH_L23, SH_R4, SH_R8, SH_R16, SH_R28, SH_R34, SH_R36, SH_R37, SH_R38
  } shift_t;

  typedef struct packed {
    logic   en;
    logic   clr;
    opnd_t  a;
    opnd_t  b;
    shift_t sh;
  } mac_op_t;

  typedef enum logic [2:0] {
    REG_KP_POS, REG_KD_POS, REG_KI_POS, REG_KP_ATT, REG_KD_ATT, REG_KI_ATT, REG_VEHICLE
  } cfg_reg_t;

  localparam logic REQ_COEF = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam opnd_t ONE28     = 34'sd268435456;
  localparam opnd_t PI28      = 34'sd843314857;
  localparam opnd_t TWO_PI28  = 34'sd1686629713;
  localparam opnd_t HALF_PI28 = 34'sd421657428;
  localparam logic signed [16:0] PI12     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI12 = 17'sd25736;
  localparam opnd_t HUNDREDTH = 34'sd167772;
  localparam opnd_t SCALE_256 = 34'sd256;
  localparam logic [15:0] SPEED_MAX = 16'd53632;
  localparam logic [59:0] SQRT_LIM  = 60'd2876498689;
  localparam acc_t  ROT_RND   = acc_t'(64'd1 << 39);

  // Reciprocals rounded up; exact floor division for operands below 2^31.
  localparam opnd_t RCP72 = opnd_t'(((64'd1 << 38) + 64'd71) / 64'd72);
  localparam opnd_t RCP42 = opnd_t'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam opnd_t RCP20 = opnd_t'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam opnd_t RCP6  = opnd_t'(((64'd1 << 34) + 64'd5) / 64'd6);

  function automatic logic [15:0] lane_u(input logic [47:0] w, input logic [1:0] k);
    case (k)
      2'd0:    return w[15:0];
      2'd1:    return w[31:16];
      default: return w[47:32];
    endcase
  endfunction

  function automatic logic signed [15:0] lane_s(input logic [47:0] w,
                                                input logic [1:0] k);
    return $signed(lane_u(w, k));
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Two correction steps cover the whole range of a yaw difference.
  function automatic logic signed [16:0] wrap_yaw(input logic signed [16:0] e);
    logic signed [16:0] t;
    t = e;
    if (t > PI12) t = t - TWO_PI12;
    else if (t < -PI12) t = t + TWO_PI12;
    if (t > PI12) t = t - TWO_PI12;
    else if (t < -PI12) t = t + TWO_PI12;
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- src/mcpm_in_if.sv -----
// ----------------------------------------------------------------------------
// mcpm_in_if
// Request channel: coefficient writes and control steps.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcpm_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [4:0]         coef_index;
  logic signed [31:0] coef_value;
  logic [47:0]        des_position;
  logic [47:0]        des_velocity;
  logic [47:0]        des_acceleration;
  logic signed [14:0] des_yaw;
  logic [47:0]        des_ang_rate;
  logic [47:0]        cur_position;
  logic [47:0]        cur_velocity;
  logic [47:0]        cur_attitude;
  logic [47:0]        cur_ang_rate;

  modport source (
    output valid, req_type, coef_index, coef_value, des_position, des_velocity,
           des_acceleration, des_yaw, des_ang_rate, cur_position, cur_velocity,
           cur_attitude, cur_ang_rate,
    input  ready
  );
  modport sink (
    input  valid, req_type, coef_index, coef_value, des_position, des_velocity,
           des_acceleration, des_yaw, des_ang_rate, cur_position, cur_velocity,
           cur_attitude, cur_ang_rate,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/mcpm_out_if.sv -----
// ----------------------------------------------------------------------------
// mcpm_out_if
// Result channel: one rotor speed command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcpm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rotor_index;
  logic [15:0] speed_cmd;
  logic        last_rotor;
  logic        speed_saturated;

  modport source (
    output valid, rotor_index, speed_cmd, last_rotor, speed_saturated,
    input  ready
  );
  modport sink (
    input  valid, rotor_index, speed_cmd, last_rotor, speed_saturated,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/multirotor_cascaded_pid_mixer_top.sv -----
// ----------------------------------------------------------------------------
// multirotor_cascaded_pid_mixer_top
// Cascaded position/attitude PID with rotor mixing, on one shared MAC unit.
// ----------------------------------------------------------------------------
//   channel  | direction | beat
//   in_ch    | sink      | coefficient write or one control step
//   out_ch   | source    | one rotor speed command
//   cfg_*    | APB r/w   | gains and vehicle constants, 8-byte stride
//
// A coefficient write goes straight into the mixing table. After a control step
// is taken, the shared multiply-accumulate unit runs with as many angle
// reduction steps as the yaw angles need; then each rotor skips the 16-step
// square root when its speed is zero or clamped and uses it otherwise.
// Reset is synchronous; it clears the integrals, not the mixing table.
// in_ch.ready is high only when the block is idle; each result beat waits
// in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multirotor_cascaded_pid_mixer_top_macros.svh"

module multirotor_cascaded_pid_mixer_top #(
  parameter int MAX_ROTORS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mcpm_in_if.sink     in_ch,
  mcpm_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import mcpm_pkg::*;

  localparam int SLOT_ROTORS = 8;
  localparam logic [3:0] ROT_LIM =
    4'((MAX_ROTORS < SLOT_ROTORS) ? MAX_ROTORS : SLOT_ROTORS);

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_RED, S_TAY, S_ROT, S_ATT, S_THR, S_INT, S_MIX, S_SQRT, S_OUT
  } state_t;

  state_t      state_r;
  logic [1:0]  k_r;
  logic [3:0]  sub_r;
  logic        pass_r;
  logic [2:0]  rot_r;
  logic [3:0]  n_r;

  logic [47:0] kp_pos_r, kd_pos_r, ki_pos_r, kp_att_r, kd_att_r, ki_att_r;
  logic [51:0] veh_r;

  logic [47:0] dpos_r, dvel_r, dacc_r, drate_r, cpos_r, cvel_r, catt_r, crate_r;
  logic signed [14:0] dyaw_r;

  logic signed [15:0] r_r [3];
  logic signed [16:0] ea_r [3];
  logic signed [31:0] u_r [4];
  logic signed [31:0] pint_r [3];
  logic signed [31:0] aint_r [3];
  logic signed [33:0] ang_r;
  logic signed [30:0] x2_r;
  logic signed [29:0] sn_r, cs_r;
  logic [22:0]        dl_r;

  logic        out_valid_r, out_sat_r, out_last_r;
  logic [15:0] out_speed_r;
  logic        sq_start_r;

  logic signed [31:0] mix_mem [32];
  logic signed [31:0] mem_q_r;
  logic [4:0]         rd_addr;

  mac_op_t mac_op;
  acc_t    acc;
  logic    sq_done;
  logic [15:0] sq_root;

  logic signed [16:0] ep_k, ev_k, er_k, yaw_err;
  opnd_t acc_lo, one_m_acc, yaw28;
  logic signed [15:0] rot_v, att_lane_p;
  logic signed [63:0] pint_sum, aint_sum;
  logic [15:0] mass, grav, invg;
  logic [3:0]  n_eff;
  logic        last_rot, in_ready, cfg_wr;

  mcpm_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  mcpm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (acc[35:4]),
    .done     (sq_done),
    .root     (sq_root)
  );

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_pos_r <= '0; kd_pos_r <= '0; ki_pos_r <= '0;
      kp_att_r <= '0; kd_att_r <= '0; ki_att_r <= '0;
      veh_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[5:3])
        REG_KP_POS:  kp_pos_r <= cfg_pwdata[47:0];
        REG_KD_POS:  kd_pos_r <= cfg_pwdata[47:0];
        REG_KI_POS:  ki_pos_r <= cfg_pwdata[47:0];
        REG_KP_ATT:  kp_att_r <= cfg_pwdata[47:0];
        REG_KD_ATT:  kd_att_r <= cfg_pwdata[47:0];
        REG_KI_ATT:  ki_att_r <= cfg_pwdata[47:0];
        REG_VEHICLE: veh_r    <= cfg_pwdata[51:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[5:3])
      REG_KP_POS:  cfg_prdata = 64'(kp_pos_r);
      REG_KD_POS:  cfg_prdata = 64'(kd_pos_r);
      REG_KI_POS:  cfg_prdata = 64'(ki_pos_r);
      REG_KP_ATT:  cfg_prdata = 64'(kp_att_r);
      REG_KD_ATT:  cfg_prdata = 64'(kd_att_r);
      REG_KI_ATT:  cfg_prdata = 64'(ki_att_r);
      REG_VEHICLE: cfg_prdata = 64'(veh_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------- mixing table ----------------
  assign rd_addr = {rot_r, sub_r[1:0]};

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready && in_ch.req_type == REQ_COEF) begin
      mix_mem[in_ch.coef_index] <= in_ch.coef_value;
    end
    mem_q_r <= mix_mem[rd_addr];
  end

  // ---------------- operand helpers ----------------
  assign mass = veh_r[15:0];
  assign grav = veh_r[31:16];
  assign invg = veh_r[47:32];
  assign n_eff = (veh_r[51:48] > ROT_LIM) ? ROT_LIM : veh_r[51:48];

  assign ep_k = 17'(lane_s(dpos_r, k_r)) - 17'(lane_s(cpos_r, k_r));
  assign ev_k = 17'(lane_s(dvel_r, k_r)) - 17'(lane_s(cvel_r, k_r));
  assign er_k = 17'(lane_s(drate_r, k_r)) - 17'(lane_s(crate_r, k_r));

  assign acc_lo    = acc[33:0];
  assign one_m_acc = ONE28 - acc_lo;
  assign yaw28     = {{2{catt_r[47]}}, catt_r[47:32], 16'd0};

  assign att_lane_p = lane_s(catt_r, {1'b0, pass_r});
  assign rot_v      = sat16((acc + ROT_RND) >>> 40);
  assign yaw_err    = wrap_yaw(17'(dyaw_r) - 17'(lane_s(catt_r, 2'd2)));
  assign pint_sum   = 64'(pint_r[k_r]) + ((acc + 64'sd32768) >>> 16);
  assign aint_sum   = 64'(aint_r[k_r]) + ((acc + 64'sd524288) >>> 20);
  assign last_rot   = (({1'b0, rot_r} + 4'd1) == n_r);
  assign in_ready   = (state_r == S_IDLE);

  // ---------------- MAC microprogram ----------------
  always_comb begin
    mac_op     = '0;
    mac_op.sh  = SH_0;
    case (state_r)
      S_POS: begin
        case (sub_r)
          4'd0: begin
            mac_op.en = 1'b1; mac_op.clr = 1'b1;
            mac_op.a = opnd_t'(lane_u(kp_pos_r, k_r)); mac_op.b = opnd_t'(ep_k);
          end
          4'd1: begin
            mac_op.en = 1'b1;
            mac_op.a = opnd_t'(lane_u(kd_pos_r, k_r)); mac_op.b = opnd_t'(ev_k);
          end
          4'd2: begin
            mac_op.en = 1'b1; mac_op.sh = SH_R8;
            mac_op.a = opnd_t'(lane_u(ki_pos_r, k_r)); mac_op.b = opnd_t'(pint_r[k_r]);
          end
          4'd3: begin
            mac_op.en = 1'b1;
            mac_op.a = opnd_t'(lane_s(dacc_r, k_r)); mac_op.b = SCALE_256;
          end
          default: ;
        endcase
      end
      S_TAY: begin
        // Taylor series by Horner: each divide is a reciprocal multiply.
        mac_op.clr = 1'b1;
        case (sub_r)
          4'd0: begin mac_op.en = 1'b1; mac_op.a = ang_r; mac_op.b = ang_r;
                      mac_op.sh = SH_R28; end
          4'd1: begin mac_op.en = 1'b1; mac_op.a = acc_lo; mac_op.b = RCP72;
                      mac_op.sh = SH_R38; end
          4'd2: begin mac_op.en = 1'b1; mac_op.a = opnd_t'(x2_r); mac_op.b = one_m_acc;
                      mac_op.sh = SH_R28; end
          4'd3: begin mac_op.en = 1'b1; mac_op.a = acc_lo; mac_op.b = RCP42;
                      mac_op.sh = SH_R37; end
          4'd4: begin mac_op.en = 1'b1; mac_op.a = opnd_t'(x2_r); mac_op.b = one_m_acc;
                      mac_op.sh = SH_R28; end
          4'd5: begin mac_op.en = 1'b1; mac_op.a = acc_lo; mac_op.b = RCP20;
                      mac_op.sh = SH_R36; end
          4'd6: begin mac_op.en = 1'b1; mac_op.a = opnd_t'(x2_r); mac_op.b = one_m_acc;
                      mac_op.sh = SH_R28; end
          4'd7: begin mac_op.en = 1'b1; mac_op.a = acc_lo; mac_op.b = RCP6;
                      mac_op.sh = SH_R34; end
          4'd8: begin mac_op.en = 1'b1; mac_op.a = ang_r; mac_op.b = one_m_acc;
                      mac_op.sh = SH_R28; end
          default: ;
        endcase
      end
      S_ROT: begin
        case (sub_r)
          4'd0: begin
            mac_op.en = 1'b1; mac_op.clr = 1'b1;
            mac_op.a = opnd_t'(r_r[0]);
            mac_op.b = pass_r ? opnd_t'(cs_r) : opnd_t'(sn_r);
          end
          4'd1: begin
            mac_op.en = 1'b1;
            mac_op.a = pass_r ? opnd_t'(r_r[1]) : -opnd_t'(r_r[1]);
            mac_op.b = pass_r ? opnd_t'(sn_r) : opnd_t'(cs_r);
          end
          4'd2: begin
            // Wide rotation result times 1/g, split at bit 23.
            mac_op.en = 1'b1; mac_op.clr = 1'b1; mac_op.sh = SH_L23;
            mac_op.a = $signed(acc[56:23]); mac_op.b = opnd_t'(invg);
          end
          4'd3: begin
            mac_op.en = 1'b1;
            mac_op.a = opnd_t'(dl_r); mac_op.b = opnd_t'(invg);
          end
          default: ;
        endcase
      end
      S_ATT: begin
        case (sub_r)
          4'd0: begin
            mac_op.en = 1'b1; mac_op.clr = 1'b1;
            mac_op.a = opnd_t'(lane_u(kp_att_r, k_r)); mac_op.b = opnd_t'(ea_r[k_r]);
          end
          4'd1: begin
            mac_op.en = 1'b1;
            mac_op.a = opnd_t'(lane_u(kd_att_r, k_r)); mac_op.b = opnd_t'(er_k);
          end
          4'd2: begin
            mac_op.en = 1'b1; mac_op.sh = SH_R4;
            mac_op.a = opnd_t'(lane_u(ki_att_r, k_r)); mac_op.b = opnd_t'(aint_r[k_r]);
          end
          default: ;
        endcase
      end
      S_THR: begin
        case (sub_r)
          4'd0: begin
            mac_op.en = 1'b1; mac_op.clr = 1'b1;
            mac_op.a = opnd_t'(mass); mac_op.b = opnd_t'(grav);
          end
          4'd1: begin
            mac_op.en = 1'b1;
            mac_op.a = opnd_t'(mass); mac_op.b = opnd_t'(r_r[2]);
          end
          default: ;
        endcase
      end
      S_INT: begin
        case (sub_r)
          4'd0: begin
            mac_op.en = 1'b1; mac_op.clr = 1'b1;
            mac_op.a = opnd_t'(ep_k); mac_op.b = HUNDREDTH;
          end
          4'd1: begin
            mac_op.en = 1'b1; mac_op.clr = 1'b1;
            mac_op.a = opnd_t'(ea_r[k_r]); mac_op.b = HUNDREDTH;
          end
          default: ;
        endcase
      end
      S_MIX: begin
        if (sub_r >= 4'd1 && sub_r <= 4'd4) begin
          mac_op.en  = 1'b1;
          mac_op.clr = (sub_r == 4'd1);
          mac_op.sh  = SH_R16;
          mac_op.a   = opnd_t'(mem_q_r);
          mac_op.b   = opnd_t'(u_r[sub_r[1:0] - 2'd1]);
        end
      end
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      sub_r       <= '0;
      pass_r      <= 1'b0;
      rot_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      sq_start_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pint_r[i] <= '0;
        aint_r[i] <= '0;
      end
    end else begin
      sq_start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.req_type == REQ_STEP) begin
            dpos_r  <= in_ch.des_position;
            dvel_r  <= in_ch.des_velocity;
            dacc_r  <= in_ch.des_acceleration;
            dyaw_r  <= in_ch.des_yaw;
            drate_r <= in_ch.des_ang_rate;
            cpos_r  <= in_ch.cur_position;
            cvel_r  <= in_ch.cur_velocity;
            catt_r  <= in_ch.cur_attitude;
            crate_r <= in_ch.cur_ang_rate;
            k_r     <= '0;
            sub_r   <= '0;
            state_r <= S_POS;
          end
        end
        S_POS: begin
          if (sub_r == 4'd4) begin
            r_r[k_r] <= sat16((acc + 64'sd128) >>> 8);
            sub_r    <= '0;
            if (k_r == 2'd2) begin
              ang_r   <= yaw28;
              pass_r  <= 1'b0;
              state_r <= S_RED;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end else begin
            sub_r <= sub_r + 4'd1;
          end
        end
        S_RED: begin
          // Reduce to one turn, then fold into the range from -pi/2 to pi/2.
          if (ang_r > PI28) begin
            ang_r <= ang_r - TWO_PI28;
          end else if (ang_r < -PI28) begin
            ang_r <= ang_r + TWO_PI28;
          end else begin
            if (ang_r > HALF_PI28) ang_r <= PI28 - ang_r;
            else if (ang_r < -HALF_PI28) ang_r <= -PI28 - ang_r;
            sub_r   <= '0;
            state_r <= S_TAY;
          end
        end
        S_TAY: begin
          sub_r <= sub_r + 4'd1;
          if (sub_r == 4'd1) x2_r <= acc[30:0];
          if (sub_r == 4'd9) begin
            sub_r <= '0;
            if (!pass_r) begin
              sn_r    <= acc[29:0];
              ang_r   <= yaw28 + HALF_PI28;
              pass_r  <= 1'b1;
              state_r <= S_RED;
            end else begin
              cs_r    <= acc[29:0];
              pass_r  <= 1'b0;
              state_r <= S_ROT;
            end
          end
        end
        S_ROT: begin
          sub_r <= sub_r + 4'd1;
          if (sub_r == 4'd2) dl_r <= acc[22:0];
          if (sub_r == 4'd4) begin
            ea_r[{1'b0, pass_r}] <= 17'(rot_v) - 17'(att_lane_p);
            sub_r <= '0;
            if (pass_r) begin
              ea_r[2] <= yaw_err;
              pass_r  <= 1'b0;
              k_r     <= '0;
              state_r <= S_ATT;
            end else begin
              pass_r <= 1'b1;
            end
          end
        end
        S_ATT: begin
          if (sub_r == 4'd3) begin
            u_r[k_r + 2'd1] <= sat32((acc + 64'sd8) >>> 4);
            sub_r <= '0;
            if (k_r == 2'd2) state_r <= S_THR;
            else k_r <= k_r + 2'd1;
          end else begin
            sub_r <= sub_r + 4'd1;
          end
        end
        S_THR: begin
          if (sub_r == 4'd2) begin
            u_r[0]  <= sat32(acc);
            sub_r   <= '0;
            k_r     <= '0;
            state_r <= S_INT;
          end else begin
            sub_r <= sub_r + 4'd1;
          end
        end
        S_INT: begin
          sub_r <= sub_r + 4'd1;
          if (sub_r == 4'd1) pint_r[k_r] <= sat32(pint_sum);
          if (sub_r == 4'd2) begin
            aint_r[k_r] <= sat32(aint_sum);
            sub_r <= '0;
            if (k_r == 2'd2) begin
              n_r     <= n_eff;
              rot_r   <= '0;
              state_r <= (n_eff == 4'd0) ? S_IDLE : S_MIX;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_MIX: begin
          sub_r <= sub_r + 4'd1;
          if (sub_r == 4'd5) begin
            sub_r      <= '0;
            out_last_r <= last_rot;
            if (acc <= 64'sd0) begin
              out_speed_r <= '0;
              out_sat_r   <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (acc[63:4] >= SQRT_LIM) begin
              out_speed_r <= SPEED_MAX;
              out_sat_r   <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              sq_start_r <= 1'b1;
              state_r    <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            out_speed_r <= sq_root;
            out_sat_r   <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              rot_r   <= rot_r + 3'd1;
              state_r <= S_MIX;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.rotor_index     = rot_r;
  assign out_ch.speed_cmd       = out_speed_r;
  assign out_ch.last_rotor      = out_last_r;
  assign out_ch.speed_saturated = out_sat_r;

  // ---------------- assertions ----------------
  `MCPM_ASSERT_IMP(a_out_blocks_in, out_valid_r, !in_ready, "result pending while ready")
  `MCPM_ASSERT_IMP(a_sat_speed, out_valid_r && out_sat_r, out_speed_r == SPEED_MAX,
                   "saturated beat without full speed")
  `MCPM_ASSERT_IMP(a_rotor_range, out_valid_r, {1'b0, rot_r} < n_r, "rotor beyond count")
  `MCPM_ASSERT_NXT(a_last_idle, out_valid_r && out_ch.ready && out_last_r, in_ready,
                   "no return to idle after last rotor")

endmodule

`default_nettype wire

// ----- src/mcpm_mac.sv -----
// ----------------------------------------------------------------------------
// mcpm_mac
// Shared signed multiply-accumulate unit with a selectable product scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpm_mac (
  input  logic              clk,
  input  mcpm_pkg::mac_op_t op,
  output mcpm_pkg::acc_t    acc
);
  import mcpm_pkg::*;

  logic signed [67:0] prod;
  acc_t term;
  acc_t acc_r;

  assign prod = 68'(op.a) * 68'(op.b);

  always_comb begin
    case (op.sh)
      SH_0:    term = acc_t'(prod);
      SH_L23:  term = acc_t'(prod <<< 23);
      SH_R4:   term = acc_t'(prod >>> 4);
      SH_R8:   term = acc_t'(prod >>> 8);
      SH_R16:  term = acc_t'(prod >>> 16);
      SH_R28:  term = acc_t'(prod >>> 28);
      SH_R34:  term = acc_t'(prod >>> 34);
      SH_R36:  term = acc_t'(prod >>> 36);
      SH_R37:  term = acc_t'(prod >>> 37);
      SH_R38:  term = acc_t'(prod >>> 38);
      default: term = acc_t'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= (op.clr ? acc_t'(0) : acc_r) + term;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ----- src/mcpm_isqrt.sv -----
// ----------------------------------------------------------------------------
// mcpm_isqrt
// Integer square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpm_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  logic [31:0] rem_r, res_r, bit_r;
  logic [3:0]  cnt_r;
  logic        act_r, done_r;
  logic [31:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= radicand;
        res_r <= '0;
        bit_r <= 32'h4000_0000;
        cnt_r <= 4'd15;
        act_r <= 1'b1;
      end else if (act_r) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[15:0];

endmodule

`default_nettype wire
